### hw/rtl/der_pkg.sv
// ----------------------------------------------------------------------------
// DER TLV parser package
// Shared constants, codes and types for the DER tag-length-value parser.
// ----------------------------------------------------------------------------
package der_pkg;

  // Longest long-form length accepted, in bytes.
  localparam int unsigned MaxLenBytes = 4;
  // Width of the arc accumulator for object identifiers.
  localparam int unsigned ArcWidth    = 32;
  // Counter width for remaining length bytes.
  localparam int unsigned LenCntW     = $clog2(MaxLenBytes + 1);

  // Tags whose contents are consumed rather than descended into.
  localparam logic [7:0] TagBoolean     = 8'h01;
  localparam logic [7:0] TagInteger     = 8'h02;
  localparam logic [7:0] TagBitString   = 8'h03;
  localparam logic [7:0] TagOctetString = 8'h04;
  localparam logic [7:0] TagOid         = 8'h06;
  localparam logic [7:0] TagPrintable   = 8'h13;
  localparam logic [7:0] TagUtcTime     = 8'h17;
  localparam logic [7:0] TagGenTime     = 8'h18;

  // Boolean content byte that reads as true.
  localparam logic [7:0] BoolTrue = 8'hff;

  // Parser phase.
  typedef enum logic [1:0] {
    PhTag,
    PhLen,
    PhLong,
    PhContent
  } der_phase_e;

  // Result kind codes.
  typedef enum logic [2:0] {
    KindHeader,
    KindContent,
    KindBoolean,
    KindFirstArcs,
    KindArc,
    KindLenError,
    KindArcOverflow
  } der_kind_e;

  // One result word.
  typedef struct packed {
    der_kind_e   kind;
    logic [7:0]  tag_value;
    logic [31:0] element_length;
    logic [31:0] payload;
    logic [31:0] second_arc;
    logic        element_last;
  } der_result_t;

  // True for tags whose contents the parser consumes.
  function automatic logic is_consumed(input logic [7:0] t);
    return (t == TagBoolean) || (t == TagInteger) || (t == TagBitString) ||
           (t == TagOctetString) || (t == TagOid) || (t == TagPrintable) ||
           (t == TagUtcTime) || (t == TagGenTime);
  endfunction

endpackage

### hw/rtl/der_stream_if.sv
// ----------------------------------------------------------------------------
// DER TLV parser stream interfaces
// Valid/ready channels for input bytes and for parser results.
// ----------------------------------------------------------------------------

// Input byte channel.
interface der_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_start;

  modport source (output valid, output data_byte, output stream_start, input ready);
  modport sink   (input valid, input data_byte, input stream_start, output ready);
endinterface

// Result channel.
interface der_out_if import der_pkg::*; ;
  logic        valid;
  logic        ready;
  der_kind_e   kind;
  logic [7:0]  tag_value;
  logic [31:0] element_length;
  logic [31:0] payload;
  logic [31:0] second_arc;
  logic        element_last;

  modport source (output valid, output kind, output tag_value, output element_length,
                  output payload, output second_arc, output element_last, input ready);
  modport sink   (input valid, input kind, input tag_value, input element_length,
                  input payload, input second_arc, input element_last, output ready);
endinterface

### hw/rtl/der_tlv_stream_parser.sv
// ----------------------------------------------------------------------------
// DER TLV stream parser
// Walks tag, length and value of a DER byte stream and emits header,
// content, boolean, object identifier arc and error results.
// ----------------------------------------------------------------------------
// The parser takes one byte per clock cycle while the output buffer has
// room and gives at most one registered result for each byte. Each byte
// updates the parse state through one pass of shallow logic (an 8-bit shift
// for lengths, a 7-bit shift for arcs, a 32-bit decrement of the content
// count). Results go into a two-word output buffer, so input bytes keep
// flowing while one result waits; the input stalls whenever both buffer
// words are occupied, and resumes the cycle after the sink takes a word. A
// byte with stream_start set restarts the parser and is read as a tag.
module der_tlv_stream_parser
  import der_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  der_in_if.sink    in_i,
  der_out_if.source out_o
);

  // Parse state registers.
  der_phase_e           phase_q, phase_d;
  logic [7:0]           tag_q, tag_d;
  logic [LenCntW-1:0]   left_q, left_d;
  logic [31:0]          lacc_q, lacc_d;
  logic [31:0]          rem_q, rem_d;
  logic [ArcWidth-1:0]  arc_q, arc_d;
  logic                 first_q, first_d;
  logic                 ovf_q, ovf_d;

  // Output buffer: head word drives the output, second word catches overflow.
  der_result_t          head_q, spare_q;
  logic [1:0]           cnt_q, cnt_d;

  der_result_t          res;
  logic                 res_valid;
  logic                 accept, push, pop;

  // Current state with stream_start applied.
  der_phase_e           ph_cur;
  logic [7:0]           tag_cur;
  logic [LenCntW-1:0]   left_cur;
  logic [31:0]          lacc_cur, rem_cur;
  logic [ArcWidth-1:0]  arc_cur;
  logic                 first_cur, ovf_cur;

  // Shared decode of the incoming byte.
  logic [7:0]           b;
  logic [6:0]           n7;
  logic [31:0]          long_acc, hdr_len, rem_dec;
  logic [LenCntW-1:0]   left_dec;
  logic                 long_done, hdr_now, len_err, go_content, c_last;
  logic [ArcWidth-1:0]  arc_n;
  logic                 ovf_n;

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = (cnt_q != 2'd2);
  assign b  = in_i.data_byte;
  assign n7 = b[6:0];

  // A start byte makes the parser behave as if just out of reset.
  assign ph_cur    = in_i.stream_start ? PhTag : phase_q;
  assign tag_cur   = in_i.stream_start ? 8'h00 : tag_q;
  assign left_cur  = in_i.stream_start ? '0 : left_q;
  assign lacc_cur  = in_i.stream_start ? '0 : lacc_q;
  assign rem_cur   = in_i.stream_start ? '0 : rem_q;
  assign arc_cur   = in_i.stream_start ? '0 : arc_q;
  assign first_cur = in_i.stream_start ? 1'b0 : first_q;
  assign ovf_cur   = in_i.stream_start ? 1'b0 : ovf_q;

  // Length decode.
  assign long_acc  = {lacc_cur[23:0], b};
  assign left_dec  = (left_cur != '0) ? left_cur - LenCntW'(1) : '0;
  assign long_done = (left_dec == '0);
  assign hdr_len   = (ph_cur == PhLong) ? long_acc : (b[7] ? 32'd0 : {24'd0, b});
  assign hdr_now   = ((ph_cur == PhLen) && (!b[7] || (n7 == 7'd0))) ||
                     ((ph_cur == PhLong) && long_done);
  assign len_err   = (ph_cur == PhLen) && b[7] && (32'(n7) > MaxLenBytes);
  assign go_content = is_consumed(tag_cur) && (hdr_len != 32'd0);

  // Content count and arc accumulation.
  assign rem_dec = (rem_cur != 32'd0) ? rem_cur - 32'd1 : 32'd0;
  assign c_last  = (rem_dec == 32'd0);
  assign arc_n   = {arc_cur[ArcWidth-8:0], b[6:0]};
  assign ovf_n   = ovf_cur || (arc_cur[ArcWidth-1 -: 7] != 7'd0);

  // Next phase.
  always_comb begin
    phase_d = ph_cur;
    case (ph_cur)
      PhTag: phase_d = PhLen;
      PhLen: begin
        if (hdr_now) begin
          phase_d = go_content ? PhContent : PhTag;
        end else if (len_err) begin
          phase_d = PhTag;
        end else begin
          phase_d = PhLong;
        end
      end
      PhLong: begin
        if (hdr_now) begin
          phase_d = go_content ? PhContent : PhTag;
        end
      end
      PhContent: begin
        if (c_last) begin
          phase_d = PhTag;
        end
      end
      default: phase_d = PhTag;
    endcase
  end

  // Result word and datapath state.
  always_comb begin
    tag_d   = tag_cur;
    left_d  = left_cur;
    lacc_d  = lacc_cur;
    rem_d   = rem_cur;
    arc_d   = arc_cur;
    first_d = first_cur;
    ovf_d   = ovf_cur;
    res_valid          = 1'b0;
    res.kind           = KindHeader;
    res.tag_value      = tag_cur;
    res.element_length = 32'd0;
    res.payload        = 32'd0;
    res.second_arc     = 32'd0;
    res.element_last   = 1'b0;
    case (ph_cur)
      PhTag: tag_d = b;
      PhLen, PhLong: begin
        if (ph_cur == PhLong) begin
          lacc_d = long_acc;
          left_d = left_dec;
        end
        if (hdr_now) begin
          rem_d   = hdr_len;
          first_d = 1'b0;
          arc_d   = '0;
          ovf_d   = 1'b0;
          res_valid          = 1'b1;
          res.kind           = KindHeader;
          res.element_length = hdr_len;
          res.element_last   = !go_content;
        end else if (len_err) begin
          res_valid        = 1'b1;
          res.kind         = KindLenError;
          res.payload      = {25'd0, n7};
          res.element_last = 1'b1;
        end else if (ph_cur == PhLen) begin
          left_d = n7[LenCntW-1:0];
          lacc_d = 32'd0;
        end
      end
      PhContent: begin
        rem_d = rem_dec;
        if (tag_cur == TagBoolean) begin
          // Only the first boolean byte gives a result.
          if (!first_cur) begin
            first_d          = 1'b1;
            res_valid        = 1'b1;
            res.kind         = KindBoolean;
            res.payload      = {31'd0, b == BoolTrue};
            res.element_last = 1'b1;
          end
        end else if (tag_cur == TagOid) begin
          if (b[7]) begin
            // Arc continues; an arc cut off by the end is dropped.
            arc_d = c_last ? '0 : arc_n;
            ovf_d = c_last ? 1'b0 : ovf_n;
          end else begin
            arc_d            = '0;
            ovf_d            = 1'b0;
            first_d          = 1'b1;
            res_valid        = 1'b1;
            res.element_last = c_last;
            if (ovf_n) begin
              res.kind = KindArcOverflow;
            end else if (!first_cur) begin
              // First subidentifier splits into two arcs.
              res.kind = KindFirstArcs;
              if (arc_n < ArcWidth'(40)) begin
                res.payload    = 32'd0;
                res.second_arc = 32'(arc_n);
              end else if (arc_n < ArcWidth'(80)) begin
                res.payload    = 32'd1;
                res.second_arc = 32'(arc_n - ArcWidth'(40));
              end else begin
                res.payload    = 32'd2;
                res.second_arc = 32'(arc_n - ArcWidth'(80));
              end
            end else begin
              res.kind    = KindArc;
              res.payload = 32'(arc_n);
            end
          end
        end else begin
          res_valid        = 1'b1;
          res.kind         = KindContent;
          res.payload      = {24'd0, b};
          res.element_last = c_last;
        end
      end
      default: ;
    endcase
  end

  // Parse state update on each accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhTag;
      tag_q   <= '0;
      left_q  <= '0;
      lacc_q  <= '0;
      rem_q   <= '0;
      arc_q   <= '0;
      first_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      tag_q   <= tag_d;
      left_q  <= left_d;
      lacc_q  <= lacc_d;
      rem_q   <= rem_d;
      arc_q   <= arc_d;
      first_q <= first_d;
      ovf_q   <= ovf_d;
    end
  end

  // Output buffer occupancy.
  assign push  = accept && res_valid;
  assign pop   = out_o.valid && out_o.ready;
  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Output buffer words; the spare word moves to the head when it drains.
  always_ff @(posedge clk_i) begin
    case (cnt_q)
      2'd0: begin
        if (push) begin
          head_q <= res;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_q <= res;
        end else if (push) begin
          spare_q <= res;
        end
      end
      2'd2: begin
        if (pop) begin
          head_q <= spare_q;
        end
      end
      default: ;
    endcase
  end

  // Result channel.
  assign out_o.valid          = (cnt_q != 2'd0);
  assign out_o.kind           = head_q.kind;
  assign out_o.tag_value      = head_q.tag_value;
  assign out_o.element_length = head_q.element_length;
  assign out_o.payload        = head_q.payload;
  assign out_o.second_arc     = head_q.second_arc;
  assign out_o.element_last   = head_q.element_last;

`ifndef SYNTH
  // The buffer never holds more than two words.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer count out of range");

  // While in content, at least one content byte is still owed.
  a_content_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhContent) |-> (rem_q != 32'd0))
    else $error("content phase with zero bytes remaining");

  // While reading long-form length, the byte count is within bounds.
  a_long_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhLong) |-> ((left_q != '0) && (32'(left_q) <= MaxLenBytes)))
    else $error("long length count out of range");

  // Only first-arc results carry a second arc.
  a_second_arc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.kind != KindFirstArcs)) |-> (out_o.second_arc == 32'd0))
    else $error("second arc set on a result that is not a first-arc result");
`endif

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// DER TLV stream parser testbench
// Drives DER byte words into the parser and checks every result word against
// a cycle-free decoder kept in step with each accepted byte. Directed tests
// cover the length forms, the boolean, object identifier and error cases.
// Random certificates then run under bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb;
  import der_pkg::*;

  // Constructed and other descended tags used by the stimulus.
  localparam logic [7:0] TagSequence = 8'h30;
  localparam logic [7:0] TagSet      = 8'h31;
  localparam logic [7:0] TagCtx0     = 8'hA0;
  localparam logic [7:0] TagCtx3     = 8'hA3;
  localparam logic [7:0] TagNull     = 8'h05;

  // Output stall patterns.
  typedef enum int {
    RxSteady,
    RxRandom,
    RxPattern,
    RxSparse
  } rx_mode_e;

  logic clk_i;
  logic rst_ni;

  der_in_if  in_if ();
  der_out_if out_if ();

  der_tlv_stream_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Decoder state, kept apart from the design.
  der_phase_e           phase_q;
  logic [7:0]           tag_q;
  logic [LenCntW-1:0]   len_left_q;
  logic [31:0]          len_acc_q;
  logic [31:0]          remain_q;
  logic [ArcWidth-1:0]  arc_q;
  logic                 first_seen_q;
  logic                 arc_ovf_q;

  // Result words still to come, oldest first.
  der_result_t decoded_q[$];

  // Byte strings built by the stimulus.
  logic [7:0] tlv_bytes[$];
  logic [7:0] tlv_body[$];

  int unsigned err_cnt = 0;
  int unsigned byte_cnt;
  bit          tx_bursty;
  int unsigned tx_burst_left;

  // Long hold requests from the tests; the receiver counts the ones it took.
  int unsigned hold_len;
  int unsigned hold_reqs;
  int unsigned hold_done = 0;
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  rx_mode_e    rx_mode   = RxSteady;
  logic [31:0] rx_cyc    = '0;

  // Clock with a period of 20.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Decoder
  // ---------------------------------------------------------------------------

  function automatic void clear_parser();
    phase_q      = PhTag;
    tag_q        = '0;
    len_left_q   = '0;
    len_acc_q    = '0;
    remain_q     = '0;
    arc_q        = '0;
    first_seen_q = 1'b0;
    arc_ovf_q    = 1'b0;
  endfunction

  function automatic der_result_t make_result(der_kind_e k, logic [31:0] len,
                                              logic [31:0] pay, logic [31:0] sec,
                                              logic lst);
    der_result_t r;
    r.kind           = k;
    r.tag_value      = tag_q;
    r.element_length = len;
    r.payload        = pay;
    r.second_arc     = sec;
    r.element_last   = lst;
    return r;
  endfunction

  // The length is complete: emit the header and pick the next phase.
  function automatic der_result_t close_header(logic [31:0] len);
    logic consumed;
    consumed = tag_q inside {TagBoolean, TagInteger, TagBitString, TagOctetString,
                             TagOid, TagPrintable, TagUtcTime, TagGenTime};
    remain_q     = len;
    first_seen_q = 1'b0;
    arc_q        = '0;
    arc_ovf_q    = 1'b0;
    if (consumed && len != 0) begin
      phase_q = PhContent;
      return make_result(KindHeader, len, '0, '0, 1'b0);
    end
    phase_q = PhTag;
    return make_result(KindHeader, len, '0, '0, 1'b1);
  endfunction

  // Advances the decoder by one byte; returns 1 when the byte gives a result.
  function automatic bit decode_byte(logic [7:0] b, logic start, output der_result_t r);
    logic [6:0]          n;
    logic                lst;
    logic [ArcWidth-1:0] v;
    r = make_result(KindHeader, '0, '0, '0, 1'b0);
    if (start) clear_parser();
    case (phase_q)
      PhTag: begin
        tag_q   = b;
        phase_q = PhLen;
        return 1'b0;
      end
      PhLen: begin
        n = b[6:0];
        if (!b[7] || n == 0) begin
          r = close_header(b[7] ? 32'd0 : 32'(b));
          return 1'b1;
        end
        if (n > MaxLenBytes) begin
          phase_q = PhTag;
          r = make_result(KindLenError, '0, 32'(n), '0, 1'b1);
          return 1'b1;
        end
        len_left_q = LenCntW'(n);
        len_acc_q  = '0;
        phase_q    = PhLong;
        return 1'b0;
      end
      PhLong: begin
        len_acc_q = {len_acc_q[23:0], b};
        if (len_left_q != 0) len_left_q--;
        if (len_left_q == 0) begin
          r = close_header(len_acc_q);
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        if (remain_q != 0) remain_q--;
        lst = (remain_q == 0);
        if (lst) phase_q = PhTag;
        // Only the first boolean byte counts; the rest are swallowed.
        if (tag_q == TagBoolean) begin
          if (first_seen_q) return 1'b0;
          first_seen_q = 1'b1;
          r = make_result(KindBoolean, '0, (b == BoolTrue) ? 32'd1 : 32'd0, '0, 1'b1);
          return 1'b1;
        end
        if (tag_q != TagOid) begin
          r = make_result(KindContent, '0, 32'(b), '0, lst);
          return 1'b1;
        end
        // Object identifier: collect base-128 groups into one arc.
        if (arc_q[ArcWidth-1 -: 7] != 0) arc_ovf_q = 1'b1;
        arc_q = {arc_q[ArcWidth-8:0], b[6:0]};
        if (b[7]) begin
          // An arc cut off by the end of the content is dropped.
          if (lst) begin
            arc_q     = '0;
            arc_ovf_q = 1'b0;
          end
          return 1'b0;
        end
        v     = arc_q;
        arc_q = '0;
        if (arc_ovf_q) begin
          arc_ovf_q    = 1'b0;
          first_seen_q = 1'b1;
          r = make_result(KindArcOverflow, '0, '0, '0, lst);
        end else if (!first_seen_q) begin
          first_seen_q = 1'b1;
          if (v < 40)
            r = make_result(KindFirstArcs, '0, 32'd0, 32'(v), lst);
          else if (v < 80)
            r = make_result(KindFirstArcs, '0, 32'd1, 32'(v - 40), lst);
          else
            r = make_result(KindFirstArcs, '0, 32'd2, 32'(v - 80), lst);
        end else begin
          r = make_result(KindArc, '0, 32'(v), '0, lst);
        end
        return 1'b1;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and output stalls
  // ---------------------------------------------------------------------------

  function automatic void compare_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  function automatic void check_result();
    der_result_t want;
    if (decoded_q.size() == 0) begin
      err_cnt++;
      $display("%0t: unexpected result word, expected none, actual kind %0d tag %0h",
               $time, out_if.kind, out_if.tag_value);
      return;
    end
    want = decoded_q.pop_front();
    compare_field("kind", 32'(want.kind), 32'(out_if.kind));
    compare_field("tag_value", 32'(want.tag_value), 32'(out_if.tag_value));
    compare_field("element_length", want.element_length, out_if.element_length);
    compare_field("payload", want.payload, out_if.payload);
    compare_field("second_arc", want.second_arc, out_if.second_arc);
    compare_field("element_last", 32'(want.element_last), 32'(out_if.element_last));
  endfunction

  // Checks each accepted word and decides the next ready value. A long hold
  // request overrides the stall pattern for its whole length.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) check_result();
      if (hold_done != hold_reqs) begin
        hold_left = hold_len;
        hold_done = hold_reqs;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        case (rx_mode)
          RxSteady:  out_if.ready <= 1'b1;
          RxRandom:  out_if.ready <= ($urandom_range(0, 3) != 0);
          RxPattern: out_if.ready <= (rx_cyc[2:0] < 3'd5);
          default:   out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
      rx_cyc++;
    end
  end

  // ---------------------------------------------------------------------------
  // Byte sender
  // ---------------------------------------------------------------------------

  // Offers one byte word and predicts its result once it is accepted.
  task automatic send_byte(logic [7:0] b, logic start);
    der_result_t r;
    if (tx_bursty && tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    if (tx_burst_left != 0) tx_burst_left--;
    in_if.valid        <= 1'b1;
    in_if.data_byte    <= b;
    in_if.stream_start <= start;
    do @(posedge clk_i); while (!in_if.ready);
    if (decode_byte(b, start, r)) decoded_q = {decoded_q, r};
    byte_cnt++;
  endtask

  task automatic send_seq(logic start, logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i], start && i == 0);
  endtask

  // Stops offering bytes until every predicted word has arrived.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (decoded_q.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------

  // Short form where it fits and is chosen, else long form of 1 to 4 bytes.
  task automatic append_length(int unsigned len);
    int unsigned need;
    int unsigned n;
    if (len < 128 && $urandom_range(0, 3) != 0) begin
      if (len == 0 && $urandom_range(0, 1) == 1)
        tlv_bytes = {tlv_bytes, 8'h80};
      else
        tlv_bytes = {tlv_bytes, 8'(len)};
    end else begin
      need = (len < 256) ? 1 : (len < 65536) ? 2 : (len < 32'h0100_0000) ? 3 : 4;
      n = $urandom_range(need, MaxLenBytes);
      tlv_bytes = {tlv_bytes, 8'h80 | 8'(n)};
      for (int i = n - 1; i >= 0; i--) tlv_bytes = {tlv_bytes, 8'(len >> (8 * i))};
    end
  endtask

  // Base-128 groups, most significant first.
  task automatic append_arc(logic [63:0] v);
    int groups;
    groups = 1;
    while (groups < 10 && (v >> (7 * groups)) != 0) groups++;
    for (int i = groups - 1; i >= 0; i--)
      tlv_body = {tlv_body, {i != 0, 7'(v >> (7 * i))}};
  endtask

  // Builds one well-formed element with random content into tlv_bytes.
  task automatic build_element();
    logic [7:0]  tag;
    logic [63:0] v;
    int unsigned pick;
    int unsigned cnt;
    int unsigned claimed;
    tlv_body.delete();
    tlv_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      // Descended element: the header only, children follow as elements.
      case ($urandom_range(0, 4))
        0: tag = TagSequence;
        1: tag = TagSet;
        2: tag = TagCtx0;
        3: tag = TagCtx3;
        default: tag = TagNull;
      endcase
      claimed = $urandom_range(0, 200);
    end else if (pick < 25) begin
      tag = TagBoolean;
      cnt = $urandom_range(1, 3);
      for (int i = 0; i < cnt; i++) begin
        case ($urandom_range(0, 2))
          0: tlv_body = {tlv_body, BoolTrue};
          1: tlv_body = {tlv_body, 8'h00};
          default: tlv_body = {tlv_body, 8'($urandom)};
        endcase
      end
      claimed = tlv_body.size();
    end else if (pick < 55) begin
      tag = TagOid;
      cnt = $urandom_range(1, 5);
      for (int i = 0; i < cnt; i++) begin
        case ($urandom_range(0, 5))
          0: v = $urandom_range(0, 39);
          1: v = $urandom_range(40, 79);
          2: v = $urandom_range(80, 1000);
          3: v = 64'($urandom);
          4: v = 64'($urandom_range(0, 127));
          default: v = {$urandom, $urandom} >> $urandom_range(0, 31);
        endcase
        append_arc(v);
      end
      // Sometimes the content ends inside the last arc.
      if ($urandom_range(0, 6) == 0) tlv_body = tlv_body[0:$-1];
      claimed = tlv_body.size();
    end else begin
      case ($urandom_range(0, 5))
        0: tag = TagInteger;
        1: tag = TagBitString;
        2: tag = TagOctetString;
        3: tag = TagPrintable;
        4: tag = TagUtcTime;
        default: tag = TagGenTime;
      endcase
      cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(128, 300) : $urandom_range(0, 16);
      for (int i = 0; i < cnt; i++) tlv_body = {tlv_body, 8'($urandom)};
      claimed = cnt;
    end
    tlv_bytes = {tlv_bytes, tag};
    append_length(claimed);
    foreach (tlv_body[i]) tlv_bytes = {tlv_bytes, tlv_body[i]};
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Descended header, zero length in the 0x80 form, and the widest length.
  task automatic test_headers();
    send_seq(1'b1, '{TagSequence, 8'h03});
    send_seq(1'b0, '{TagInteger, 8'h80});
    send_seq(1'b0, '{TagOctetString, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
  endtask

  // Length of length too large; the restart cuts the open element short.
  task automatic test_errors();
    send_seq(1'b1, '{TagBitString, 8'hFF});
    send_seq(1'b0, '{TagPrintable, 8'h85});
  endtask

  // A true boolean followed by a byte that gives no result.
  task automatic test_boolean();
    send_seq(1'b0, '{TagBoolean, 8'h02, BoolTrue, 8'h00});
  endtask

  // First arcs in all three ranges, a multi-byte arc, a cut-off arc and an
  // arc too wide for the accumulator.
  task automatic test_oid();
    send_seq(1'b0, '{TagOid, 8'h03, 8'h27, 8'h8F, 8'h7F});
    send_seq(1'b0, '{TagOid, 8'h01, 8'h4F});
    send_seq(1'b0, '{TagOid, 8'h02, 8'h50, 8'h81});
    send_seq(1'b0, '{TagOid, 8'h05, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F});
  endtask

  // Random certificates: mostly well-formed elements, some noise, some
  // length errors and some truncated elements ended by a restart.
  task automatic test_random(int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned elems;
    int unsigned pick;
    int unsigned drop;
    bit          first;
    bit          cut;
    stop_at = byte_cnt + n_bytes;
    while (byte_cnt < stop_at) begin
      elems = $urandom_range(1, 8);
      first = 1'b1;
      for (int e = 0; e < elems; e++) begin
        pick = $urandom_range(0, 99);
        cut  = 1'b0;
        if (pick < 8) begin
          tlv_bytes.delete();
          repeat ($urandom_range(1, 6)) tlv_bytes = {tlv_bytes, 8'($urandom)};
        end else if (pick < 13) begin
          tlv_bytes = '{8'($urandom), 8'($urandom_range(8'h85, 8'hFF))};
        end else begin
          build_element();
          if ($urandom_range(0, 19) == 0) begin
            cut  = 1'b1;
            drop = $urandom_range(1, tlv_bytes.size() - 1);
            repeat (drop) tlv_bytes = tlv_bytes[0:$-1];
          end
        end
        send_seq(first, tlv_bytes);
        first = 1'b0;
        if (cut) break;
      end
    end
  endtask

  // The output holds off while bytes keep coming, so the parser fills up
  // and stalls its input.
  task automatic test_long_hold();
    tx_bursty = 1'b0;
    hold_len  = 150;
    hold_reqs++;
    tlv_bytes = '{TagInteger, 8'h40};
    repeat (64) tlv_bytes = {tlv_bytes, 8'($urandom)};
    send_seq(1'b1, tlv_bytes);
    tx_bursty = 1'b1;
  endtask

  // The input pauses until every result is out, then resumes.
  task automatic test_drain_pause();
    wait_drained();
    send_seq(1'b1, '{TagUtcTime, 8'h02, 8'h31, 8'h39});
  endtask

  initial begin
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.data_byte    = '0;
    in_if.stream_start = 1'b0;
    byte_cnt           = 0;
    tx_bursty          = 1'b1;
    tx_burst_left      = 0;
    hold_len           = 0;
    hold_reqs          = 0;
    clear_parser();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_headers();
    test_errors();
    test_boolean();
    test_oid();
    test_random(850);
    test_long_hold();
    test_drain_pause();
    test_random(850);

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/der_pkg.sv
hw/rtl/der_stream_if.sv
hw/rtl/der_tlv_stream_parser.sv
verif/tb.sv
